// ===== src/hsss_pkg.sv =====
// Shared types, constants and pattern tables for the half-step stepper sequencer.
// Depends on nothing; every other file in src imports it.
package hsss_pkg;

	// Field widths of the request and status items
	localparam int COUNT_BITS = 24;
	localparam int STEP_W     = 24;
	localparam int ANGLE_W    = 24;
	localparam int SPR_W      = 16;
	localparam int COILS_W    = 4;
	localparam int LEFT_W     = 24;

	localparam logic [SPR_W-1:0] SPR_RESET = 16'd4096;

	// Command codes
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_LOAD   = 2'd1;
	localparam logic [1:0] CMD_ROTATE = 2'd2;

	// Degrees*256 to steps: divide by 92160 = 45 * 2^11.
	// The 2^11 part is a shift, the 45 part a reciprocal multiply.
	localparam int DEG_SHIFT   = 11;
	localparam int PROD_W      = ANGLE_W + SPR_W;
	localparam int SCALED_W    = PROD_W - DEG_SHIFT;
	localparam int RECIP_W     = 30;
	localparam int RECIP_SHIFT = 35;
	localparam logic [RECIP_W-1:0] RECIP_45 = 30'd763549742;
	localparam int RPROD_W     = SCALED_W + RECIP_W;
	localparam int MAG_W       = STEP_W;

	// Largest count the step counter holds
	localparam logic [32:0] COUNT_LIMIT = (33'd1 << COUNT_BITS) - 33'd1;

	// Queue between front and back
	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Result queue in the back part
	localparam int OQ_DEPTH = 2;
	localparam int OQPTR_W  = $clog2(OQ_DEPTH);
	localparam int OQCNT_W  = $clog2(OQ_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_TICK,
		OP_LOAD,
		OP_HOLD
	} op_kind_t;

	// Classified operation handed from front to back
	typedef struct packed {
		op_kind_t              kind;
		logic                  cw;
		logic [COUNT_BITS-1:0] count;
	} op_t;

	typedef struct packed {
		logic [1:0]                 command;
		logic signed [STEP_W-1:0]   step_count;
		logic signed [ANGLE_W-1:0]  angle;
	} request_t;

	typedef struct packed {
		logic [COILS_W-1:0] coils;
		logic               stepped;
		logic [LEFT_W-1:0]  steps_left;
		logic               clockwise_dir;
	} status_t;

	// Clockwise half-step coil patterns, indexed by phase - 1
	function automatic logic [COILS_W-1:0] cw_pattern(input logic [2:0] idx);
		logic [COILS_W-1:0] pat;
		unique case (idx)
			3'd0: pat = 4'h8;
			3'd1: pat = 4'hC;
			3'd2: pat = 4'h4;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h2;
			3'd5: pat = 4'h3;
			3'd6: pat = 4'h1;
			default: pat = 4'h9;
		endcase
		return pat;
	endfunction

	// Counter-clockwise patterns: clockwise table with the pin order mirrored
	function automatic logic [COILS_W-1:0] ccw_pattern(input logic [2:0] idx);
		logic [COILS_W-1:0] pat;
		unique case (idx)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			default: pat = 4'h9;
		endcase
		return pat;
	endfunction

	// Clamp a step magnitude to the counter range
	function automatic logic [COUNT_BITS-1:0] sat_count(input logic [MAG_W-1:0] mag);
		logic [COUNT_BITS-1:0] res;
		if (33'(mag) > COUNT_LIMIT) begin
			res = COUNT_BITS'(COUNT_LIMIT);
		end else begin
			res = COUNT_BITS'(mag);
		end
		return res;
	endfunction

endpackage

// ===== src/half_step_stepper_sequencer.sv =====
// Top level of the half-step stepper sequencer: front, operation queue and back.
// Depends on hsss_pkg, hsss_front, hsss_queue and hsss_back.
//
//   port group              handshake              carries
//   request                 push / full            command, step_count, angle
//   status                  pop / empty            coils, stepped, steps_left, clockwise_dir
//   cfg_data                cfg_valid / cfg_ready  steps_per_rev
//
// One request per cycle sustained while full is low; each passes the stage 1 register, two more
// front stages for the angle multiplies, the queue and the state update ahead of its status.
// Reset: steps_per_rev 4096, phase 1, counter-clockwise, no steps left, coils off.
// full rises when eight requests are in flight or queued; a stalled status side fills the
// two-entry status queue and then the operation queue before full asserts.
module half_step_stepper_sequencer import hsss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  request_t         request,
	output logic             empty,
	input  logic             pop,
	output status_t          status,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [SPR_W-1:0] cfg_data
);

	logic q_wr;
	logic q_rd;
	logic q_empty;
	op_t  q_wr_item;
	op_t  q_rd_item;

	// Accept and classify requests
	hsss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_wr      (q_wr),
		.q_item    (q_wr_item),
		.q_rd      (q_rd)
	);

	// Decouple front and back
	hsss_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_item (q_wr_item),
		.rd_en   (q_rd),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	// Carry out operations and queue status
	hsss_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_rd_item),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.status  (status)
	);

endmodule

// ===== src/hsss_queue.sv =====
// Small in-order queue of classified operations between front and back.
// Depends on hsss_pkg for op_t and the queue depth.
module hsss_queue import hsss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  op_t  wr_item,
	input  logic rd_en,
	output op_t  rd_item,
	output logic empty
);

	op_t               mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	// Store incoming operations
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign rd_item = mem[rd_ptr_q];
	assign empty   = (cnt_q == '0);

endmodule

// ===== src/hsss_front.sv =====
// Front part: accepts requests, holds steps_per_rev, converts angles to step counts
// and pushes classified operations toward the back. Depends on hsss_pkg.
module hsss_front import hsss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  request_t         request,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [SPR_W-1:0] cfg_data,
	output logic             q_wr,
	output op_t              q_item,
	input  logic             q_rd
);

	logic              accept;
	logic [SPR_W-1:0]  spr_q;
	logic [QCNT_W-1:0] used_q;

	op_kind_t          kind_in;
	logic              rot_in;
	logic [MAG_W-1:0]  load_mag_in;
	logic [ANGLE_W-1:0] abs_angle_in;

	logic               valid_s1, valid_s2, valid_s3;
	op_kind_t           kind_s1, kind_s2, kind_s3;
	logic               rot_s1, rot_s2, rot_s3;
	logic               neg_s1, neg_s2, neg_s3;
	logic               load_cw_s1, load_cw_s2, load_cw_s3;
	logic [MAG_W-1:0]   load_mag_s1, load_mag_s2, load_mag_s3;
	logic [ANGLE_W-1:0] abs_angle_s1;
	logic [PROD_W-1:0]  prod_s2;
	logic [RPROD_W-1:0] recip_s3;

	logic [MAG_W-1:0]   quot;
	logic               rot_cw;

	assign accept    = push & ~full;
	assign cfg_ready = 1'b1;

	// Hold the revolution setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q <= SPR_RESET;
		end else if (cfg_valid) begin
			spr_q <= cfg_data;
		end
	end

	// Count requests in flight or queued; stall when the queue could overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			case ({accept, q_rd})
				2'b10:   used_q <= used_q + 1'b1;
				2'b01:   used_q <= used_q - 1'b1;
				default: used_q <= used_q;
			endcase
		end
	end

	assign full = (used_q == QCNT_W'(QDEPTH));

	// Classify the command
	always_comb begin
		rot_in = 1'b0;
		unique case (request.command)
			CMD_TICK:   kind_in = OP_TICK;
			CMD_LOAD:   kind_in = OP_LOAD;
			CMD_ROTATE: begin
				kind_in = OP_LOAD;
				rot_in  = 1'b1;
			end
			default:    kind_in = OP_HOLD;
		endcase
	end

	// Take magnitudes of the signed step count and angle
	assign load_mag_in  = request.step_count[STEP_W-1] ?
		MAG_W'(~request.step_count + 1'b1) : MAG_W'(request.step_count);
	assign abs_angle_in = request.angle[ANGLE_W-1] ?
		ANGLE_W'(~request.angle + 1'b1) : ANGLE_W'(request.angle);

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: register classified request
	always_ff @(posedge clk) begin
		kind_s1      <= kind_in;
		rot_s1       <= rot_in;
		neg_s1       <= request.angle[ANGLE_W-1];
		load_cw_s1   <= ~request.step_count[STEP_W-1] & (|request.step_count);
		load_mag_s1  <= load_mag_in;
		abs_angle_s1 <= abs_angle_in;
	end

	// Stage 2: angle magnitude times steps per revolution
	always_ff @(posedge clk) begin
		kind_s2     <= kind_s1;
		rot_s2      <= rot_s1;
		neg_s2      <= neg_s1;
		load_cw_s2  <= load_cw_s1;
		load_mag_s2 <= load_mag_s1;
		prod_s2     <= PROD_W'(abs_angle_s1) * PROD_W'(spr_q);
	end

	// Stage 3: drop the 2^11 factor and multiply by the reciprocal of 45
	always_ff @(posedge clk) begin
		kind_s3     <= kind_s2;
		rot_s3      <= rot_s2;
		neg_s3      <= neg_s2;
		load_cw_s3  <= load_cw_s2;
		load_mag_s3 <= load_mag_s2;
		recip_s3    <= RPROD_W'(prod_s2[PROD_W-1:DEG_SHIFT]) * RPROD_W'(RECIP_45);
	end

	// Finish the quotient; a zero step number turns counter-clockwise
	assign quot   = MAG_W'(recip_s3[RPROD_W-1:RECIP_SHIFT]);
	assign rot_cw = ~neg_s3 & (|quot);

	always_comb begin
		q_wr        = valid_s3;
		q_item.kind = kind_s3;
		q_item.cw   = rot_s3 ? rot_cw : load_cw_s3;
		q_item.count = sat_count(rot_s3 ? quot : load_mag_s3);
	end

endmodule

// ===== src/hsss_back.sv =====
// Back part: applies operations to phase, direction and count, drives the coil
// pattern and queues one status item per operation. Depends on hsss_pkg.
module hsss_back import hsss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  op_t     q_item,
	output logic    q_rd,
	output logic    empty,
	input  logic    pop,
	output status_t status
);

	logic [2:0]            phase_q;
	logic                  cw_q;
	logic [COUNT_BITS-1:0] remaining_q;
	logic [COILS_W-1:0]    coil_q;

	logic [2:0]            phase_nxt;
	logic                  cw_nxt;
	logic [COUNT_BITS-1:0] remaining_nxt;
	logic [COILS_W-1:0]    coil_nxt;
	logic                  stepped;

	status_t               oq_mem [OQ_DEPTH];
	logic [OQPTR_W-1:0]    oq_wr_q;
	logic [OQPTR_W-1:0]    oq_rd_q;
	logic [OQCNT_W-1:0]    oq_cnt_q;
	logic                  oq_pop;

	assign oq_pop = pop & ~empty;
	assign q_rd   = ~q_empty & (oq_cnt_q != OQCNT_W'(OQ_DEPTH));

	// Work out the state after this operation
	always_comb begin
		phase_nxt     = phase_q;
		cw_nxt        = cw_q;
		remaining_nxt = remaining_q;
		coil_nxt      = coil_q;
		stepped       = 1'b0;
		unique case (q_item.kind)
			OP_TICK: begin
				if (remaining_q != '0) begin
					coil_nxt      = cw_q ? cw_pattern(phase_q) : ccw_pattern(phase_q);
					phase_nxt     = phase_q + 3'd1;
					remaining_nxt = remaining_q - 1'b1;
					stepped       = 1'b1;
				end
			end
			OP_LOAD: begin
				cw_nxt        = q_item.cw;
				remaining_nxt = q_item.count;
			end
			default: begin
			end
		endcase
	end

	// Advance the motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			cw_q        <= 1'b0;
			remaining_q <= '0;
			coil_q      <= '0;
		end else if (q_rd) begin
			phase_q     <= phase_nxt;
			cw_q        <= cw_nxt;
			remaining_q <= remaining_nxt;
			coil_q      <= coil_nxt;
		end
	end

	// Store status items
	always_ff @(posedge clk) begin
		if (q_rd) begin
			oq_mem[oq_wr_q] <= '{
				coils:         coil_nxt,
				stepped:       stepped,
				steps_left:    LEFT_W'(remaining_nxt),
				clockwise_dir: cw_nxt
			};
		end
	end

	// Advance status queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (q_rd) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			case ({q_rd, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	assign empty  = (oq_cnt_q == '0);
	assign status = oq_mem[oq_rd_q];

endmodule

// ===== tb/half_step_stepper_sequencer_tb.sv =====
// Self-checking testbench for the half-step stepper sequencer: a queue-fed driver, a
// checking monitor and a step-count predictor. Depends on hsss_pkg and the RTL under src.
module half_step_stepper_sequencer_tb;
	import hsss_pkg::*;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam longint     DEG_DIV      = 92160;
	localparam logic [31:0] CW_COILS    = 32'h9132_64C8;  // phase 1 pattern in the low nibble
	localparam int         PHASE_COUNT  = 8;
	localparam int         HOLD_CYCLES  = 150;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         REPORT_LIMIT = 40;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             push      = 1'b0;
	logic             full;
	request_t         request   = '0;
	logic             empty;
	logic             pop       = 1'b0;
	status_t          status;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [SPR_W-1:0] cfg_data  = '0;

	// Motor state as the predictor sees it
	logic [3:0]        motor_phase = 4'd1;
	logic              motor_cw    = 1'b0;
	logic [LEFT_W-1:0] motor_left  = '0;
	logic [3:0]        motor_coils = '0;
	logic [SPR_W-1:0]  cur_spr     = SPR_RESET;

	request_t pending_requests[$];
	status_t  expected_status[$];
	status_t  want_status;

	int  mismatch_count = 0;
	int  results_seen   = 0;
	int  next_hold_at   = 200;
	int  hold_left      = 0;
	int  take_gap       = 0;
	int  send_gap       = 0;
	int  idle_cycles    = 0;
	bit  offering;
	bit  quiet          = 1'b0;

	half_step_stepper_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.empty     (empty),
		.pop       (pop),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic longint widen24(input logic [23:0] v);
		return longint'({{40{v[23]}}, v});
	endfunction

	// Set direction and remaining count from a signed step number, clamped to the counter
	function automatic void load_count(input longint n);
		longint mag;
		longint top;
		top = longint'((64'd1 << COUNT_BITS) - 64'd1);
		if (n > 0) begin
			motor_cw = 1'b1;
			mag = n;
		end else begin
			motor_cw = 1'b0;
			mag = -n;
		end
		if (mag > top) begin
			mag = top;
		end
		motor_left = LEFT_W'(mag);
	endfunction

	// Apply one request to the motor state and return the status it produces
	function automatic status_t predict_status(input request_t r);
		status_t    s;
		logic [3:0] pat;
		logic [2:0] idx;
		longint     prod;
		s = '0;
		case (r.command)
			CMD_TICK: begin
				if (motor_left != '0) begin
					idx = 3'(motor_phase - 4'd1);
					pat = CW_COILS[idx*4 +: 4];
					motor_coils = motor_cw ? pat : {pat[0], pat[1], pat[2], pat[3]};
					motor_phase = (motor_phase >= 4'(PHASE_COUNT)) ? 4'd1 : motor_phase + 4'd1;
					motor_left = motor_left - 1'b1;
					s.stepped = 1'b1;
				end
			end
			CMD_LOAD: begin
				load_count(widen24(r.step_count));
			end
			CMD_ROTATE: begin
				prod = widen24(r.angle) * longint'({48'd0, cur_spr});
				load_count(prod / DEG_DIV);
			end
			default: begin
			end
		endcase
		s.coils = motor_coils;
		s.steps_left = motor_left;
		s.clockwise_dir = motor_cw;
		return s;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%0t: %s got %0h expected %0h", $time, what, got, want);
		end
	endtask

	task automatic add_request(input logic [1:0] cmd, input logic [23:0] steps,
			input logic [23:0] ang);
		request_t r;
		r.command = cmd;
		r.step_count = steps;
		r.angle = ang;
		pending_requests.push_back(r);
	endtask

	task automatic add_ticks(input int n);
		repeat (n) add_request(CMD_TICK, 24'($urandom), 24'($urandom));
	endtask

	// Mostly load or rotate followed by ticks, with some noise mixed in
	task automatic make_random(input int n);
		int made;
		int kind;
		int mag;
		int k;
		int sel;
		int ang;
		made = 0;
		add_request(CMD_ROTATE, 24'($urandom), 24'h7FFFFF);
		add_request(CMD_ROTATE, 24'($urandom), 24'h800000);
		while (made < n) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				add_request(2'($urandom), 24'($urandom), 24'($urandom));
				made++;
			end else if (kind <= 5) begin
				mag = $urandom_range(0, 40);
				add_request(CMD_LOAD, $urandom_range(0, 1) ? 24'(mag) : 24'(-mag),
					24'($urandom));
				k = mag + $urandom_range(0, 3);
				if ($urandom_range(0, 4) == 0) begin
					k = $urandom_range(0, mag);
				end
				add_ticks(k);
				made += k + 1;
			end else if (kind <= 8) begin
				sel = $urandom_range(0, 9);
				if (sel < 6) begin
					ang = $urandom_range(0, 3000);
				end else if (sel < 9) begin
					ang = $urandom_range(0, 200000);
				end else begin
					ang = int'($urandom);
				end
				if ($urandom_range(0, 1) == 1) begin
					ang = -ang;
				end
				add_request(CMD_ROTATE, 24'($urandom), 24'(ang));
				k = $urandom_range(0, 30);
				add_ticks(k);
				made += k + 1;
			end else begin
				k = $urandom_range(1, 5);
				add_ticks(k);
				made += k;
			end
		end
	endtask

	// Wait until every request is taken and every status has come back, then let it settle
	task automatic wait_drained();
		do @(negedge clk); while (pending_requests.size() != 0 || expected_status.size() != 0
			|| push);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_steps_per_rev(input logic [SPR_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_spr = v;
	endtask

	// Offer the head of the pending queue; predict its status once it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			offering = push;
			if (push && !full) begin
				expected_status.push_back(predict_status(request));
				pending_requests.delete(0);
				offering = 1'b0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					push <= 1'b1;
					request <= pending_requests[0];
					send_gap = quiet ? 0 : gap_len();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Check each status against the oldest prediction and pace pop
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_status.size() == 0) begin
					report_mismatch("status with nothing expected", 32'(status), 32'd0);
				end else begin
					want_status = expected_status.pop_front();
					if (status.coils !== want_status.coils) begin
						report_mismatch("coils", 32'(status.coils), 32'(want_status.coils));
					end
					if (status.stepped !== want_status.stepped) begin
						report_mismatch("stepped", 32'(status.stepped), 32'(want_status.stepped));
					end
					if (status.steps_left !== want_status.steps_left) begin
						report_mismatch("steps_left", 32'(status.steps_left),
							32'(want_status.steps_left));
					end
					if (status.clockwise_dir !== want_status.clockwise_dir) begin
						report_mismatch("clockwise_dir", 32'(status.clockwise_dir),
							32'(want_status.clockwise_dir));
					end
				end
				results_seen++;
				// Hold off for a long stretch while requests keep coming, to fill the block
				if (results_seen >= next_hold_at && pending_requests.size() > 40) begin
					hold_left = HOLD_CYCLES;
					next_hold_at += 500;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0) begin
					take_gap = gap_len();
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("half_step_stepper_sequencer: mismatch");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: idle tick, unused command, extremes, zero, one full phase cycle with wrap
		add_request(CMD_TICK, 24'h000000, 24'h000000);
		add_request(CMD_UNUSED, 24'hFFFFFF, 24'hFFFFFF);
		add_request(CMD_LOAD, 24'h000000, 24'hFFFFFF);
		add_request(CMD_LOAD, 24'h7FFFFF, 24'h000000);
		add_request(CMD_LOAD, 24'h800000, 24'h7FFFFF);
		add_request(CMD_ROTATE, 24'h000000, 24'h7FFFFF);
		add_request(CMD_ROTATE, 24'hFFFFFF, 24'h800000);
		add_request(CMD_ROTATE, 24'h7FFFFF, 24'h000000);
		add_request(CMD_ROTATE, 24'h800000, 24'hFFFFFF);
		add_request(CMD_LOAD, 24'd9, 24'h800000);
		add_ticks(9);
		add_request(CMD_LOAD, 24'(-3), 24'h000000);
		add_ticks(4);
		wait_drained();

		// Random phases, each under its own steps_per_rev
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: write_steps_per_rev(16'hFFFF);
				1: write_steps_per_rev(16'd1);
				3: write_steps_per_rev(16'd360);
				default: write_steps_per_rev(SPR_W'($urandom_range(1, 65535)));
			endcase
			@(negedge clk);
			quiet = (p == 3);
			make_random(200);
			wait_drained();
		end

		if (mismatch_count == 0) begin
			$display("half_step_stepper_sequencer: match");
		end else begin
			$display("half_step_stepper_sequencer: mismatch");
		end
		$finish;
	end

endmodule
